// ----- rtl/i2r_pkg.sv -----
// Shared constants, state type and digit character table for the radix digit converter.
package i2r_pkg;

  localparam int IN_VALUE_W  = 64;
  localparam int VALUE_WIDTH = 64;
  localparam int MAX_DIGITS  = 64;
  localparam int BASE_W      = 5;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 4;
  localparam int NUM_DIGIT_CODES = 16;

  // The divider consumes one chunk of the dividend per cycle.
  localparam int CHUNK_BITS  = 8;
  localparam int NUM_CHUNKS  = (VALUE_WIDTH + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int PAD_W       = NUM_CHUNKS * CHUNK_BITS;
  localparam int CHUNK_IDX_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

  localparam int DIG_AW      = $clog2(MAX_DIGITS);
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);

  localparam logic [BASE_W-1:0]  BASE_MIN     = BASE_W'(2);
  localparam logic [BASE_W-1:0]  BASE_MAX     = BASE_W'(16);
  localparam logic [DIGIT_W-1:0] FIRST_LETTER = DIGIT_W'(10);
  localparam logic [CHAR_W-1:0]  LOWER_OFFSET = CHAR_W'(8'h20);

  localparam logic [CHAR_W-1:0] DIGIT_CHARS [NUM_DIGIT_CODES] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_READ,
    ST_EMIT
  } state_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] c;
    c = DIGIT_CHARS[d];
    if (!upper && (d >= FIRST_LETTER)) begin
      c = c + LOWER_OFFSET;
    end
    return c;
  endfunction

endpackage

// ----- rtl/i2r_ifs.sv -----
// Valid/ready channel interfaces for the number input and the character output.
interface i2r_in_if import i2r_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [IN_VALUE_W-1:0] value;
  logic [BASE_W-1:0]     base;
  logic                  is_signed;
  logic                  upper_case;

  modport source (output valid, value, base, is_signed, upper_case, input ready);
  modport sink   (input valid, value, base, is_signed, upper_case, output ready);
endinterface

interface i2r_out_if import i2r_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, character, last, input ready);
  modport sink   (input valid, character, last, output ready);
endinterface

// ----- rtl/integer_to_radix_digits.sv -----
// Top level: converts one integer to its ASCII digit string in a base from 2 to 16.
// Usage
//   in_chan  : one transfer carries value, base, is_signed and upper_case. In signed
//              mode the magnitude is converted; no minus sign is produced. Bases below
//              2 count as 2, above 16 as 16.
//   out_chan : one transfer per digit, most significant first, as an ASCII code;
//              last is set on the final digit. Zero gives a single '0'.
// Timing
//   Digits come from repeated division by the base. The divider is one shared
//   long-division step that takes eight dividend bits per cycle, so each digit takes a
//   start step and then one division step per significant byte of the remaining value.
//   After the last digit is found, the READ state reads the digit store, then digits go
//   out one per cycle while out_chan.ready is high. The largest 64-bit value has
//   20 digits in base 10 and 64 in base 2. in_chan.ready is high only while idle;
//   one item at a time.
// Reset
//   rst_n is synchronous, active low; the block returns to idle with no pending
//   output. The digit store holds no reset value and needs none.
// Stall: a stalled out_chan holds character and last steady; the store is read
//   again only after the current digit has been transferred.
module integer_to_radix_digits import i2r_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  i2r_in_if.sink       in_chan,
  i2r_out_if.source    out_chan
);

  state_t state_r, state_nxt;

  logic [PAD_W-1:0]       val_r;      // remaining dividend, quotient written in place
  logic [BASE_W-1:0]      base_r;
  logic                   upper_r;
  logic [CNT_W-1:0]       cnt_r;      // digits stored so far
  logic [CHUNK_IDX_W-1:0] idx_r;      // chunk under division
  logic [DIGIT_W-1:0]     rem_r;      // running remainder
  logic [DIG_AW-1:0]      ptr_r;      // store entry being emitted
  logic [DIGIT_W-1:0]     rd_data_r;

  logic [DIGIT_W-1:0]     digit_mem [MAX_DIGITS];

  logic in_xfer, out_xfer;
  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign out_xfer = out_chan.valid && out_chan.ready;

  // ---- input conditioning: mask, magnitude, base clamp
  logic [VALUE_WIDTH-1:0] in_val, in_mag;
  logic [BASE_W-1:0]      in_base;

  always_comb begin
    in_val = in_chan.value[VALUE_WIDTH-1:0];
    if (in_chan.is_signed && in_val[VALUE_WIDTH-1]) begin
      in_mag = ~in_val + VALUE_WIDTH'(1);
    end else begin
      in_mag = in_val;
    end
    if (in_chan.base < BASE_MIN) begin
      in_base = BASE_MIN;
    end else if (in_chan.base > BASE_MAX) begin
      in_base = BASE_MAX;
    end else begin
      in_base = in_chan.base;
    end
  end

  // ---- highest nonzero chunk; division of each digit starts there
  logic [CHUNK_IDX_W-1:0] top_idx;

  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NUM_CHUNKS; i++) begin
      if (|val_r[i*CHUNK_BITS +: CHUNK_BITS]) begin
        top_idx = CHUNK_IDX_W'(i);
      end
    end
  end

  // ---- shared divider step: one chunk of restoring long division
  logic [CHUNK_BITS-1:0] div_chunk, div_quo;
  logic [DIGIT_W-1:0]    rem_new;
  logic [PAD_W-1:0]      val_div;
  logic                  quo_zero;

  always_comb begin
    logic [DIGIT_W:0] trial;
    logic [DIGIT_W-1:0] rem;
    div_chunk = val_r[idx_r*CHUNK_BITS +: CHUNK_BITS];
    rem       = rem_r;
    div_quo   = '0;
    for (int b = CHUNK_BITS - 1; b >= 0; b--) begin
      trial = {rem, div_chunk[b]};
      if (trial >= base_r) begin
        div_quo[b] = 1'b1;
        trial      = trial - base_r;
      end
      rem = trial[DIGIT_W-1:0];   // always below the base
    end
    rem_new = rem;
    val_div = val_r;
    val_div[idx_r*CHUNK_BITS +: CHUNK_BITS] = div_quo;
    quo_zero = (val_div == '0);
  end

  logic last_chunk, store_ok;
  assign last_chunk = (idx_r == '0);
  assign store_ok   = (cnt_r < CNT_W'(MAX_DIGITS));

  // ---- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_xfer) state_nxt = ST_START;
      ST_START: state_nxt = ST_DIV;
      ST_DIV: begin
        if (last_chunk) begin
          state_nxt = quo_zero ? ST_READ : ST_START;
        end
      end
      ST_READ:  state_nxt = ST_EMIT;
      ST_EMIT:  if (out_xfer && (ptr_r == '0)) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---- outputs and store control
  logic              mem_we, rd_en;
  logic [DIG_AW-1:0] rd_addr;

  always_comb begin
    in_chan.ready      = 1'b0;
    out_chan.valid     = 1'b0;
    mem_we             = 1'b0;
    rd_en              = 1'b0;
    rd_addr            = ptr_r - DIG_AW'(1);
    unique case (state_r)
      ST_IDLE: in_chan.ready = 1'b1;
      ST_START: ;
      ST_DIV:  mem_we = last_chunk && store_ok;
      ST_READ: begin
        rd_en   = 1'b1;
        rd_addr = DIG_AW'(cnt_r - CNT_W'(1));
      end
      ST_EMIT: begin
        out_chan.valid = 1'b1;
        rd_en          = out_xfer && (ptr_r != '0);   // prefetch next digit
      end
      default: ;
    endcase
  end

  assign out_chan.character = digit_char(rd_data_r, upper_r);
  assign out_chan.last      = (ptr_r == '0);

  // ---- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        cnt_r <= '0;
      end else if (mem_we) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  // ---- datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          val_r   <= PAD_W'(in_mag);
          base_r  <= in_base;
          upper_r <= in_chan.upper_case;
        end
      end
      ST_START: begin
        idx_r <= top_idx;
        rem_r <= '0;
      end
      ST_DIV: begin
        val_r <= val_div;
        rem_r <= rem_new;
        if (!last_chunk) begin
          idx_r <= idx_r - CHUNK_IDX_W'(1);
        end
      end
      ST_READ: ptr_r <= rd_addr;
      ST_EMIT: if (rd_en) ptr_r <= rd_addr;
      default: ;
    endcase
  end

  // ---- digit store, least significant digit at entry 0
  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[cnt_r[DIG_AW-1:0]] <= rem_new;
    end
    if (rd_en) begin
      rd_data_r <= digit_mem[rd_addr];
    end
  end

endmodule

// ----- rtl/i2r_checker.sv -----
// Port-level checker for the radix digit converter, bound to the top level.
module i2r_checker import i2r_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_character,
  input logic              out_last
);

  // Never takes a new number while digits are still being offered.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while output valid");

  // Division always runs before any digit can appear, so none is offered right after an input transfer.
  a_no_early_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid)
    else $error("digit offered right after input transfer");

  // Final digit transfer returns the block to idle.
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> (in_ready && !out_valid))
    else $error("not idle after last digit");

  // Digits stream back to back until the last one.
  a_stream_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> (out_valid && !in_ready))
    else $error("digit stream broken before last");

  // Stalled digit holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_character) && $stable(out_last)))
    else $error("stalled digit changed");

endmodule

bind integer_to_radix_digits i2r_checker u_i2r_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_character (out_chan.character),
  .out_last      (out_chan.last)
);
